// File: rtl/hsds_pkg.sv
// Shared types and constants for the hierarchy shortest-distance sweep.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package hsds_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int MAX_TARGETS = 64;
    localparam int WEIGHT_BITS = 32;

    localparam int NODE_W  = 10;
    localparam int EADDR_W = 12;
    localparam int ECNT_W  = 13;
    localparam int SLOT_W  = 6;
    localparam int DIST_W  = 41;

    localparam logic [ECNT_W-1:0] EDGE_LIMIT = ECNT_W'(MAX_EDGES);
    localparam logic [10:0]       NODE_LIMIT = 11'(MAX_NODES);
    localparam logic [6:0]        TGT_LIMIT  = 7'(MAX_TARGETS);
    localparam logic [DIST_W-1:0] DIST_INF   = DIST_W'(1) << 40;
    localparam logic [DIST_W-1:0] DIST_MAX   = DIST_INF - DIST_W'(1);

    localparam logic [1:0] FUNC_EDGE   = 2'd0;
    localparam logic [1:0] FUNC_TARGET = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [3:0] REG_NODE_COUNT   = 4'd0;
    localparam logic [3:0] REG_TARGET_COUNT = 4'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  edge_tail;
        logic [9:0]  edge_head;
        logic [31:0] edge_weight;
        logic [5:0]  slot_index;
        logic [9:0]  target_node;
        logic [9:0]  source_node;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  slot_out;
        logic [39:0] distance;
        logic        reachable;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]      tail;
        logic [NODE_W-1:0]      head;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_t;

    typedef struct packed {
        logic               load_edge;
        logic               set_tgt;
        logic               edge_rd;
        logic               edge_sel;    // 0 upward store, 1 downward store
        logic [EADDR_W-1:0] edge_addr;
        logic               port_a_tgt;
        logic               src_wr;
        logic [NODE_W-1:0]  src;
        logic               relax_en;
        logic               clr_wr;
        logic [NODE_W-1:0]  clr_addr;
        logic               tgt_rd;
        logic [SLOT_W-1:0]  tgt_addr;
        logic               out_load;
        logic               out_last;
        logic [10:0]        n_active;
    } cmd_t;

    typedef struct packed {
        logic [ECNT_W-1:0] up_cnt;
        logic [ECNT_W-1:0] dn_cnt;
        logic              relaxed;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/hsds_dpath.sv
// Datapath: edge stores, target table, distance memory, relax unit, result register.
// Depends on hsds_pkg; driven by hsds_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module hsds_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsds_pkg::in_item_t item,
    input  wire hsds_pkg::cmd_t     cmd,
    output hsds_pkg::status_t       status,
    output hsds_pkg::out_item_t     result
);
    import hsds_pkg::*;

    edge_t             up_mem [MAX_EDGES];
    edge_t             dn_mem [MAX_EDGES];
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [NODE_W-1:0] tgt_mem [MAX_TARGETS];

    logic [ECNT_W-1:0] up_cnt_reg, up_cnt_next;
    logic [ECNT_W-1:0] dn_cnt_reg, dn_cnt_next;
    edge_t             up_q_reg, dn_q_reg;
    logic              sel_reg;
    logic [NODE_W-1:0] tgt_q_reg;
    logic [DIST_W-1:0] dist_a_reg, dist_b_reg;
    out_item_t         result_reg;

    edge_t             ed;
    edge_t             new_edge;
    logic [NODE_W-1:0] addr_a;
    logic [41:0]       sum;
    logic [DIST_W-1:0] cand;
    logic              live;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [DIST_W-1:0] wr_data;
    logic              tgt_ok;

    assign new_edge.tail   = item.edge_tail;
    assign new_edge.head   = item.edge_head;
    assign new_edge.weight = item.edge_weight[WEIGHT_BITS-1:0];

    assign ed     = sel_reg ? dn_q_reg : up_q_reg;
    assign addr_a = cmd.port_a_tgt ? tgt_q_reg : ed.tail;

    // Saturating relax of head from tail; an unreached tail relaxes nothing
    assign sum  = 42'(dist_a_reg) + 42'(ed.weight);
    assign cand = (sum > 42'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    assign live = (11'(ed.tail) < cmd.n_active) && (11'(ed.head) < cmd.n_active)
                  && (dist_a_reg != DIST_INF);
    assign status.relaxed = cmd.relax_en && live && (cand < dist_b_reg);
    assign status.up_cnt  = up_cnt_reg;
    assign status.dn_cnt  = dn_cnt_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.clr_addr;
        wr_data = DIST_INF;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.src_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cmd.src;
            wr_data = '0;
        end
        else if (status.relaxed)
        begin
            wr_en   = 1'b1;
            wr_addr = ed.head;
            wr_data = cand;
        end
    end

    always_comb
    begin
        up_cnt_next = up_cnt_reg;
        dn_cnt_next = dn_cnt_reg;
        if (cmd.load_edge)
        begin
            if (item.edge_tail > item.edge_head && up_cnt_reg < EDGE_LIMIT)
            begin
                up_cnt_next = up_cnt_reg + 1'b1;
            end
            if (item.edge_tail < item.edge_head && dn_cnt_reg < EDGE_LIMIT)
            begin
                dn_cnt_next = dn_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_cnt_reg <= '0;
            dn_cnt_reg <= '0;
        end
        else
        begin
            up_cnt_reg <= up_cnt_next;
            dn_cnt_reg <= dn_cnt_next;
        end
    end

    // Edge stores: append on load, registered read for the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.load_edge && up_cnt_next != up_cnt_reg)
        begin
            up_mem[up_cnt_reg[EADDR_W-1:0]] <= new_edge;
        end
        if (cmd.load_edge && dn_cnt_next != dn_cnt_reg)
        begin
            dn_mem[dn_cnt_reg[EADDR_W-1:0]] <= new_edge;
        end
        if (cmd.edge_rd)
        begin
            up_q_reg <= up_mem[cmd.edge_addr];
            dn_q_reg <= dn_mem[cmd.edge_addr];
            sel_reg  <= cmd.edge_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_data;
        end
        dist_a_reg <= dist_mem[addr_a];
        dist_b_reg <= dist_mem[ed.head];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_tgt)
        begin
            tgt_mem[item.slot_index] <= item.target_node;
        end
        if (cmd.tgt_rd)
        begin
            tgt_q_reg <= tgt_mem[cmd.tgt_addr];
        end
    end

    assign tgt_ok = (11'(tgt_q_reg) < cmd.n_active) && (dist_a_reg != DIST_INF);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.slot_out  <= cmd.tgt_addr;
            result_reg.distance  <= tgt_ok ? dist_a_reg[39:0] : 40'd0;
            result_reg.reachable <= tgt_ok;
            result_reg.last      <= cmd.out_last;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// File: rtl/hsds_ctrl.sv
// Controller: configuration registers, sequencing of load, relax passes, report, clear.
// Depends on hsds_pkg; commands hsds_dpath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module hsds_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hsds_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output hsds_pkg::cmd_t          cmd,
    input  wire hsds_pkg::status_t  status
);
    import hsds_pkg::*;

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_SRC  = 11'b00000000100,
        S_PASS = 11'b00000001000,
        S_ERD  = 11'b00000010000,
        S_DRD  = 11'b00000100000,
        S_UPD  = 11'b00001000000,
        S_TRD  = 11'b00010000000,
        S_ORD  = 11'b00100000000,
        S_OLD  = 11'b01000000000,
        S_OSND = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [10:0]       nodes_reg, nodes_next;
    logic [6:0]        tgts_reg, tgts_next;
    logic [ECNT_W-1:0] j_reg, j_next;
    logic [6:0]        k_reg, k_next;
    logic [10:0]       clr_reg, clr_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic              phase_reg, phase_next;
    logic              chg_reg, chg_next;
    logic              ov_reg, ov_next;

    logic [10:0]       n_act;
    logic [6:0]        tc;
    logic [ECNT_W-1:0] cnt;
    logic              in_acc;

    assign n_act     = (nodes_reg > NODE_LIMIT) ? NODE_LIMIT : nodes_reg;
    assign tc        = (tgts_reg > TGT_LIMIT) ? TGT_LIMIT : tgts_reg;
    assign cnt       = phase_reg ? status.dn_cnt : status.up_cnt;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;

    always_comb
    begin
        nodes_next = nodes_reg;
        tgts_next  = tgts_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NODE_COUNT:   nodes_next = cfg_data[10:0];
                REG_TARGET_COUNT: tgts_next  = cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        src_next   = src_reg;
        phase_next = phase_reg;
        chg_next   = chg_reg;
        ov_next    = ov_reg;

        cmd            = '0;
        cmd.n_active   = n_act;
        cmd.edge_sel   = phase_reg;
        cmd.edge_addr  = j_reg[EADDR_W-1:0];
        cmd.src        = src_reg;
        cmd.clr_addr   = clr_reg[NODE_W-1:0];
        cmd.tgt_addr   = k_reg[SLOT_W-1:0];
        cmd.out_last   = (k_reg + 7'd1 == tc);

        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 11'd1;
                if (clr_reg == NODE_LIMIT - 11'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_item.func)
                        FUNC_EDGE:   cmd.load_edge = 1'b1;
                        FUNC_TARGET: cmd.set_tgt   = 1'b1;
                        FUNC_QUERY:
                        begin
                            src_next   = in_item.source_node;
                            state_next = S_SRC;
                        end
                        default:     ;
                    endcase
                end
            end
            S_SRC:
            begin
                cmd.src_wr = (11'(src_reg) < n_act);
                j_next     = '0;
                phase_next = 1'b0;
                chg_next   = 1'b0;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                if (j_reg < cnt)
                begin
                    state_next = S_ERD;
                end
                else if (chg_reg)
                begin
                    // repeat the pass until nothing improves
                    j_next   = '0;
                    chg_next = 1'b0;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    j_next     = '0;
                end
                else if (tc == 7'd0)
                begin
                    clr_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_TRD;
                end
            end
            S_ERD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_DRD;
            end
            S_DRD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.relax_en = 1'b1;
                if (status.relaxed)
                begin
                    chg_next = 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_PASS;
            end
            S_TRD:
            begin
                cmd.tgt_rd = 1'b1;
                state_next = S_ORD;
            end
            S_ORD:
            begin
                cmd.port_a_tgt = 1'b1;
                state_next     = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load = 1'b1;
                ov_next      = 1'b1;
                state_next   = S_OSND;
            end
            S_OSND:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (k_reg + 7'd1 == tc)
                    begin
                        clr_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        k_next     = k_reg + 7'd1;
                        state_next = S_TRD;
                    end
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            nodes_reg <= 11'd1024;
            tgts_reg  <= 7'd1;
            j_reg     <= '0;
            k_reg     <= '0;
            clr_reg   <= '0;
            src_reg   <= '0;
            phase_reg <= 1'b0;
            chg_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nodes_reg <= nodes_next;
            tgts_reg  <= tgts_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
            src_reg   <= src_next;
            phase_reg <= phase_next;
            chg_reg   <= chg_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/hierarchy_shortest_distance_sweep.sv
// Top level of the hierarchy shortest-distance sweep: controller plus datapath.
// Depends on hsds_pkg, hsds_ctrl and hsds_dpath.
//
// Usage: one input channel (in_valid/in_ready/in_item) carries three kinds of beat:
// load edge, set target slot, run query. Upward edges (tail above head) and downward
// edges (tail below head) go to separate stores; self loops are dropped. A query
// writes distance zero at the source, then relaxes the upward store in repeated
// passes until a pass improves nothing, then does the same over the downward store.
// Each edge visit steps through S_PASS, S_ERD, S_DRD and S_UPD, one edge at a time,
// paced by the single-port edge read and the distance memory round trip.
// Results leave on out_valid/out_ready/out_item, one beat per target slot in
// ascending order with last on the final beat; each result is read through S_TRD,
// S_ORD and S_OLD and held in S_OSND until taken. Hold: while the receiver stalls
// the result register and the sequencer wait. After the results the distance memory
// is swept back to unreached, one node a cycle; the same sweep runs after reset,
// during which in_ready stays low. Edge and target loads are written as accepted.
// Configuration (cfg_valid/cfg_index/cfg_data) is always ready; write it idle.
`timescale 1ns / 1ps
`default_nettype none
module hierarchy_shortest_distance_sweep (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hsds_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hsds_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [3:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import hsds_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer and configuration registers
    hsds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    // Stores, relax unit and result register
    hsds_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item),
        .cmd    (cmd),
        .status (status),
        .result (out_item)
    );

endmodule
`default_nettype wire

// File: dv/hsds_sweep_checker.sv
// Scoreboard for the hierarchy shortest-distance sweep: predicts per-target distances.
// Depends on hsds_pkg; watches the input, configuration and result channels.
`timescale 1ns / 1ps
module hsds_sweep_checker
    import hsds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int        fail_count,
    output int        pending
);
    edge_t            up_store[$];
    edge_t            dn_store[$];
    logic [9:0]       tgt_tbl[MAX_TARGETS];
    logic [10:0]      nodes_cfg;
    logic [6:0]       tgt_cfg;
    logic [40:0]      reach[MAX_NODES];
    out_item_t        due_results[$];

    function automatic logic [40:0] sat_sum(logic [40:0] d, logic [31:0] w);
        logic [40:0] s;
        s = d + 41'(w);
        return (s > DIST_MAX) ? DIST_MAX : s;
    endfunction

    function automatic void predict_distances(logic [9:0] src);
        int          n;
        int          tc;
        bit          changed;
        logic [40:0] c;
        out_item_t   r;
        n  = (nodes_cfg > NODE_LIMIT) ? MAX_NODES : int'(nodes_cfg);
        tc = (tgt_cfg > TGT_LIMIT) ? MAX_TARGETS : int'(tgt_cfg);
        foreach (reach[i]) reach[i] = DIST_INF;
        if (src < n) reach[src] = '0;
        // upward search to a fixed point: unreached tails never relax
        do
        begin
            changed = 0;
            foreach (up_store[j])
            begin
                if (up_store[j].tail < n && up_store[j].head < n &&
                    reach[up_store[j].tail] != DIST_INF)
                begin
                    c = sat_sum(reach[up_store[j].tail], up_store[j].weight);
                    if (c < reach[up_store[j].head])
                    begin
                        reach[up_store[j].head] = c;
                        changed = 1;
                    end
                end
            end
        end
        while (changed);
        // downward sweep in ascending node order
        for (int i = 0; i < n; i++)
            foreach (dn_store[j])
                if (dn_store[j].head == i && dn_store[j].tail < n &&
                    reach[dn_store[j].tail] != DIST_INF)
                begin
                    c = sat_sum(reach[dn_store[j].tail], dn_store[j].weight);
                    if (c < reach[i]) reach[i] = c;
                end
        for (int k = 0; k < tc; k++)
        begin
            r.slot_out  = 6'(k);
            r.reachable = (tgt_tbl[k] < n) && (reach[tgt_tbl[k]] != DIST_INF);
            r.distance  = r.reachable ? reach[tgt_tbl[k]][39:0] : '0;
            r.last      = (k + 1 == tc);
            due_results = {due_results, r};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        edge_t     e;
        if (!rst_n)
        begin
            up_store.delete();
            dn_store.delete();
            due_results.delete();
            foreach (tgt_tbl[i]) tgt_tbl[i] = '0;
            nodes_cfg  = 11'd1024;
            tgt_cfg    = 7'd1;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NODE_COUNT) nodes_cfg = cfg_data[10:0];
                else if (cfg_index == REG_TARGET_COUNT) tgt_cfg = cfg_data[6:0];
            end
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %p", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_item !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("%0t: mismatch exp slot %0d dist %0d reach %0d last %0d",
                                   $time, want.slot_out, want.distance, want.reachable,
                                   want.last);
                            $display(", got slot %0d dist %0d reach %0d last %0d",
                                     out_item.slot_out, out_item.distance,
                                     out_item.reachable, out_item.last);
                        end
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (in_item.func)
                    FUNC_EDGE:
                    begin
                        e.tail   = in_item.edge_tail;
                        e.head   = in_item.edge_head;
                        e.weight = in_item.edge_weight;
                        if (e.tail > e.head && up_store.size() < MAX_EDGES)
                            up_store = {up_store, e};
                        else if (e.tail < e.head && dn_store.size() < MAX_EDGES)
                            dn_store = {dn_store, e};
                    end
                    FUNC_TARGET: tgt_tbl[in_item.slot_index] = in_item.target_node;
                    FUNC_QUERY:  predict_distances(in_item.source_node);
                    default: ;
                endcase
            end
            pending = due_results.size();
        end
    end
endmodule

// File: dv/tb_hierarchy_shortest_distance_sweep.sv
// Top of the sweep testbench: clock, reset, stimulus, result stalls and verdict.
// Depends on hsds_pkg, hierarchy_shortest_distance_sweep and hsds_sweep_checker.
`timescale 1ns / 1ps
module tb_hierarchy_shortest_distance_sweep;
    import hsds_pkg::*;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT  = 5_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          no_results;   // target count was last written as zero

    hierarchy_shortest_distance_sweep dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hsds_sweep_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_hierarchy_shortest_distance_sweep: errors");
            $finish;
        end
    end

    // Receiver: alternate free-running, choppy and fully stalled stretches.
    int stall_mode;
    int stretch_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_mode   = 0;
            stretch_left = 0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stall_mode   = $urandom_range(9);
                stretch_left = (stall_mode == 9) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 200);
            end
            stretch_left--;
            if (stall_mode < 5)      out_ready <= 1'b1;
            else if (stall_mode < 9) out_ready <= ($urandom_range(1) == 1);
            else                     out_ready <= 1'b0;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [9:0] pick_node();
        return ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(15));
    endfunction

    function automatic logic [31:0] pick_weight();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5)  return $urandom_range(100);
        return $urandom;
    endfunction

    // Fill every field at random, then set the ones the beat carries.
    function automatic in_item_t noise_item();
        return in_item_t'(80'({$urandom, $urandom, $urandom}));
    endfunction

    function automatic in_item_t edge_item(logic [9:0] t, logic [9:0] h, logic [31:0] w);
        in_item_t it;
        it             = noise_item();
        it.func        = FUNC_EDGE;
        it.edge_tail   = t;
        it.edge_head   = h;
        it.edge_weight = w;
        return it;
    endfunction

    function automatic in_item_t target_item(logic [5:0] s, logic [9:0] node);
        in_item_t it;
        it             = noise_item();
        it.func        = FUNC_TARGET;
        it.slot_index  = s;
        it.target_node = node;
        return it;
    endfunction

    function automatic in_item_t query_item(logic [9:0] src);
        in_item_t it;
        it             = noise_item();
        it.func        = FUNC_QUERY;
        it.source_node = src;
        return it;
    endfunction

    // Present one beat after a gap and hold it until accepted.
    task automatic send_beat(in_item_t it, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send(in_item_t it);
        send_beat(it, pick_gap());
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] value);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom;
        if (idx == REG_TARGET_COUNT) no_results = (value[6:0] == 0);
    endtask

    // Wait for every expected result, then let the clearing pass finish; a query
    // with no targets gives no sign of completion, so allow for a whole search.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (no_results ? 60000 : 1500) @(posedge clk);
    endtask

    int        nodes_plan[5] = '{16, 2047, 5, 1, 1024};
    int        slots_plan[5] = '{64, 127, 0, 3, 20};
    int        items_plan[5] = '{6, 6, 4, 4, 6};

    initial
    begin
        int r;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cycles     = 0;
        no_results = 0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_NODE_COUNT;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of nodes and weights, self loop, ignored function.
        write_reg(REG_NODE_COUNT, 1024);
        write_reg(REG_TARGET_COUNT, 4);
        send(target_item(6'd0, 10'd0));
        send(target_item(6'd1, 10'd1023));
        send(target_item(6'd2, 10'd3));
        send(target_item(6'd3, 10'd7));
        send(edge_item(10'd3, 10'd0, 32'd0));
        send(edge_item(10'd0, 10'd7, 32'hFFFF_FFFF));
        send(edge_item(10'd1023, 10'd3, 32'd5));
        send(edge_item(10'd2, 10'd2, 32'd9));
        send(edge_item(10'd0, 10'd1023, 32'hFFFF_FFFF));
        send(edge_item(10'd7, 10'd3, 32'd1));
        begin
            in_item_t junk;
            junk      = noise_item();
            junk.func = FUNC_IGNORED;
            send(junk);
        end
        send(query_item(10'd1023));
        send(query_item(10'd3));
        send(query_item(10'd0));
        send(query_item(10'd7));
        settle();
        // drop the high nodes: edges to them ignored, such a source reaches nothing
        write_reg(REG_NODE_COUNT, 4);
        send(query_item(10'd3));
        send(query_item(10'd1023));
        settle();
        write_reg(REG_NODE_COUNT, 0);
        send(query_item(10'd0));
        settle();

        // Fill the whole target table before any phase reads it.
        for (int s = 0; s < MAX_TARGETS; s++)
            send(target_item(6'(s), pick_node()));

        // Random phases, each under its own register setting.
        foreach (nodes_plan[p])
        begin
            settle();
            write_reg(REG_NODE_COUNT, nodes_plan[p]);
            write_reg(REG_TARGET_COUNT, slots_plan[p]);
            for (int i = 0; i < items_plan[p]; i++)
            begin
                r = $urandom_range(99);
                if (r < 45)      send(edge_item(pick_node(), pick_node(), pick_weight()));
                else if (r < 65) send(target_item(6'($urandom), pick_node()));
                else if (r < 93) send(query_item(pick_node()));
                else
                begin
                    in_item_t junk;
                    junk      = noise_item();
                    junk.func = FUNC_IGNORED;
                    send(junk);
                end
            end
        end
        in_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_hierarchy_shortest_distance_sweep: clean");
        else
            $display("tb_hierarchy_shortest_distance_sweep: errors");
        $finish;
    end
endmodule
